[src/csvqm_pkg.sv]
package csvqm_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_out;
        logic       field_data;
        logic       record_separator;
        logic       any_separator;
        logic       last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    localparam t_result END_RESULT = '{
        byte_out:         8'h00,
        field_data:       1'b0,
        record_separator: 1'b1,
        any_separator:    1'b1,
        last_result:      1'b1
    };

endpackage

[src/csvqm_classify.sv]
module csvqm_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte_value,
    input  logic              i_codepoint_mark,
    input  logic              i_end_of_data,
    output csvqm_pkg::t_push  o_push,
    output logic              o_held_valid
);
    import csvqm_pkg::*;

    logic       r_quote_parity;
    logic       r_inside_quotes;
    logic       r_prev_escape;
    logic [7:0] r_held_byte;
    logic       r_held_mark;
    logic       r_held_valid;

    logic       n_quote_parity;
    logic       n_inside_quotes;
    logic       n_prev_escape;
    logic [7:0] n_held_byte;
    logic       n_held_mark;
    logic       n_held_valid;

    logic    is_dq, next_dq, next_lf, odd_q, even_q, escape, escaped;
    logic    start_q, stop_q, quoted, rec, any_sep, crlf, fmt, data;
    t_result held_res;

    // lookahead classification of the held byte against the incoming beat
    always_comb begin
        is_dq   = (r_held_byte == CH_DQ);
        next_dq = !i_end_of_data && (i_byte_value == CH_DQ);
        next_lf = !i_end_of_data && (i_byte_value == CH_LF);
        odd_q   = is_dq && !r_quote_parity;
        even_q  = is_dq && r_quote_parity;
        escape  = even_q && next_dq;
        escaped = is_dq && r_prev_escape;
        start_q = odd_q && !escaped;
        stop_q  = even_q && !escape;
        quoted  = r_inside_quotes || start_q;
        rec     = (r_held_byte == CH_LF) && !quoted;
        any_sep = rec || ((r_held_byte == CH_COMMA) && !quoted);
        crlf    = (r_held_byte == CH_CR) && next_lf;
        fmt     = is_dq && !escaped;
        data    = !(fmt || crlf || rec) && r_held_mark;

        held_res.byte_out         = r_held_byte;
        held_res.field_data       = data;
        held_res.record_separator = rec;
        held_res.any_separator    = any_sep;
        held_res.last_result      = 1'b0;
    end

    always_comb begin
        o_push.first  = r_held_valid ? held_res : END_RESULT;
        o_push.second = END_RESULT;
        o_push.count  = 2'(r_held_valid) + 2'(i_end_of_data);
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_comb begin
        n_quote_parity  = r_quote_parity;
        n_inside_quotes = r_inside_quotes;
        n_prev_escape   = r_prev_escape;
        n_held_byte     = r_held_byte;
        n_held_mark     = r_held_mark;
        n_held_valid    = r_held_valid;
        if (i_accept) begin
            if (r_held_valid) begin
                if (start_q) begin
                    n_inside_quotes = 1'b1;
                end
                if (stop_q) begin
                    n_inside_quotes = 1'b0;
                end
                n_quote_parity = r_quote_parity ^ is_dq;
                n_prev_escape  = escape;
            end
            if (i_end_of_data) begin
                n_quote_parity  = 1'b0;
                n_inside_quotes = 1'b0;
                n_prev_escape   = 1'b0;
                n_held_byte     = 8'h00;
                n_held_mark     = 1'b0;
                n_held_valid    = 1'b0;
            end else begin
                n_held_byte  = i_byte_value;
                n_held_mark  = i_codepoint_mark;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_parity  <= 1'b0;
            r_inside_quotes <= 1'b0;
            r_prev_escape   <= 1'b0;
            r_held_byte     <= 8'h00;
            r_held_mark     <= 1'b0;
            r_held_valid    <= 1'b0;
        end else begin
            r_quote_parity  <= n_quote_parity;
            r_inside_quotes <= n_inside_quotes;
            r_prev_escape   <= n_prev_escape;
            r_held_byte     <= n_held_byte;
            r_held_mark     <= n_held_mark;
            r_held_valid    <= n_held_valid;
        end
    end

    assign o_held_valid = r_held_valid;

endmodule

[src/csvqm_out_fifo.sv]
module csvqm_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  csvqm_pkg::t_push               i_push,
    input  logic                           i_pop,
    output csvqm_pkg::t_result             o_head,
    output logic                           o_not_empty,
    output logic                           o_almost_full,
    output logic [csvqm_pkg::OQ_CW-1:0]    o_count
);
    import csvqm_pkg::*;

    t_result            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wr_ptr;
    logic [OQ_AW-1:0]   r_rd_ptr;
    logic [OQ_CW-1:0]   r_count;

    logic [OQ_AW-1:0]   n_wr_ptr;
    logic [OQ_AW-1:0]   n_rd_ptr;
    logic [OQ_CW-1:0]   n_count;
    logic [OQ_AW-1:0]   wr_ptr_b;

    always_comb begin
        wr_ptr_b = r_wr_ptr + OQ_AW'(1);
        n_wr_ptr = r_wr_ptr + OQ_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + OQ_AW'(i_pop);
        n_count  = r_count + OQ_CW'(i_push.count) - OQ_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // room for two results must be left for an end beat
    assign o_head        = r_mem[r_rd_ptr];
    assign o_not_empty   = (r_count != '0);
    assign o_almost_full = (r_count > OQ_CW'(OQ_DEPTH - 2));
    assign o_count       = r_count;

endmodule

[src/csv_quote_aware_field_marker_top.sv]
// channel | valid   | stall   | fields
// in      | i_valid | o_stall | i_byte_value, i_codepoint_mark, i_end_of_data
// out     | o_valid | i_stall | o_byte_out, o_field_data, o_record_separator,
//         |         |         | o_any_separator, o_last_result
//
// one input beat per cycle while o_stall is low; a byte's result is produced when the next beat arrives
// an end beat pushes up to two results into a four-entry output queue
// o_stall rises when the queue holds more than two results
// reset clears the quote state, the held byte and the queue
module csv_quote_aware_field_marker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_codepoint_mark,
    input  logic       i_end_of_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic       o_field_data,
    output logic       o_record_separator,
    output logic       o_any_separator,
    output logic       o_last_result
);
    import csvqm_pkg::*;

    logic             in_accept;
    logic             out_pop;
    logic             held_valid;
    logic             almost_full;
    logic [OQ_CW-1:0] q_count;
    t_push            push;
    t_result          head;

    assign in_accept = i_valid && !o_stall;
    assign out_pop   = o_valid && !i_stall;

    csvqm_classify u_classify (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_byte_value     (i_byte_value),
        .i_codepoint_mark (i_codepoint_mark),
        .i_end_of_data    (i_end_of_data),
        .o_push           (push),
        .o_held_valid     (held_valid)
    );

    csvqm_out_fifo u_out_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_pop         (out_pop),
        .o_head        (head),
        .o_not_empty   (o_valid),
        .o_almost_full (almost_full),
        .o_count       (q_count)
    );

    assign o_stall            = almost_full;
    assign o_byte_out         = head.byte_out;
    assign o_field_data       = head.field_data;
    assign o_record_separator = head.record_separator;
    assign o_any_separator    = head.any_separator;
    assign o_last_result      = head.last_result;

`ifndef SYNTHESIS
    a_end_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_end_of_data |=> !held_valid)
        else $error("held byte survived an end beat");

    a_byte_sets_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_end_of_data |=> held_valid)
        else $error("byte beat not held for lookahead");

    a_end_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |->
            o_record_separator && o_any_separator && !o_field_data && o_byte_out == 8'h00)
        else $error("malformed end result");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= OQ_CW'(OQ_DEPTH))
        else $error("output queue overflow");
`endif

endmodule

[sim/testbench.sv]
module testbench;
    import csvqm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_byte_value;
    logic       i_codepoint_mark;
    logic       i_end_of_data;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_byte_out;
    logic       o_field_data;
    logic       o_record_separator;
    logic       o_any_separator;
    logic       o_last_result;

    logic       idle_on;
    int         beat_count;
    int         mismatch_count;

    // lexer shadow state
    logic       quote_odd;
    logic       in_span;
    logic       last_was_escape;
    logic [7:0] hold_byte;
    logic       hold_mark;
    logic       hold_valid;

    t_result    lexed_q[$];
    t_result    seen_result;
    t_result    due_result;

    csv_quote_aware_field_marker_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_byte_value       (i_byte_value),
        .i_codepoint_mark   (i_codepoint_mark),
        .i_end_of_data      (i_end_of_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_byte_out         (o_byte_out),
        .o_field_data       (o_field_data),
        .o_record_separator (o_record_separator),
        .o_any_separator    (o_any_separator),
        .o_last_result      (o_last_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_lexer();
        quote_odd       = 1'b0;
        in_span         = 1'b0;
        last_was_escape = 1'b0;
        hold_byte       = 8'h00;
        hold_mark       = 1'b0;
        hold_valid      = 1'b0;
    endfunction

    function automatic void lex_beat(input logic [7:0] b, input logic m, input logic e);
        logic    is_dq;
        logic    next_dq;
        logic    next_lf;
        logic    closing;
        logic    esc;
        logic    escaped;
        logic    opens;
        logic    closes;
        logic    quoted;
        logic    rec;
        logic    crlf;
        logic    fmt;
        t_result r;
        if (hold_valid) begin
            is_dq   = (hold_byte == CH_DQ);
            next_dq = !e && (b == CH_DQ);
            next_lf = !e && (b == CH_LF);
            closing = is_dq && quote_odd;
            esc     = closing && next_dq;
            escaped = is_dq && last_was_escape;
            opens   = is_dq && !quote_odd && !escaped;
            closes  = closing && !esc;
            quoted  = in_span || opens;
            rec     = (hold_byte == CH_LF) && !quoted;
            crlf    = (hold_byte == CH_CR) && next_lf;
            fmt     = is_dq && !escaped;
            r.byte_out         = hold_byte;
            r.field_data       = !(fmt || crlf || rec) && hold_mark;
            r.record_separator = rec;
            r.any_separator    = rec || ((hold_byte == CH_COMMA) && !quoted);
            r.last_result      = 1'b0;
            lexed_q = {lexed_q, r};
            if (opens) in_span = 1'b1;
            if (closes) in_span = 1'b0;
            if (is_dq) quote_odd = !quote_odd;
            last_was_escape = esc;
        end
        if (e) begin
            lexed_q = {lexed_q, END_RESULT};
            clear_lexer();
        end else begin
            hold_byte  = b;
            hold_mark  = m;
            hold_valid = 1'b1;
        end
    endfunction

    // called at a rising edge; returns at the edge that took the beat
    task automatic send_beat(input logic [7:0] b, input logic m, input logic e);
        logic took;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_byte_value     <= b;
        i_codepoint_mark <= m;
        i_end_of_data    <= e;
        do begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end while (!took);
        lex_beat(b, m, e);
        beat_count++;
    endtask

    task automatic send_text(input logic [7:0] b);
        send_beat(b, $urandom_range(0, 7) != 0, 1'b0);
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_DQ || c == CH_COMMA || c == CH_LF)
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] noisy_char();
        case ($urandom_range(0, 7))
            0: return CH_DQ;
            1: return CH_COMMA;
            2: return CH_LF;
            3: return CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_field(input logic quoted);
        int len;
        len = $urandom_range(0, 5);
        if (quoted) send_text(CH_DQ);
        repeat (len) begin
            if (quoted) begin
                case ($urandom_range(0, 7))
                    0: send_text(CH_COMMA);
                    1: send_text(CH_LF);
                    2: send_text(CH_CR);
                    3: begin
                        send_text(CH_DQ);
                        send_text(CH_DQ);
                    end
                    default: send_text(plain_char());
                endcase
            end else begin
                send_text(plain_char());
            end
        end
        if (quoted) send_text(CH_DQ);
    endtask

    task automatic send_record(input logic is_last);
        int nf;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            send_field($urandom_range(0, 2) == 0);
            if (f < nf - 1) send_text(CH_COMMA);
        end
        case ($urandom_range(0, 3))
            0, 1: send_text(CH_LF);
            2: begin
                send_text(CH_CR);
                send_text(CH_LF);
            end
            default: if (!is_last) send_text(CH_LF);
        endcase
    endtask

    task automatic send_stream();
        int nr;
        nr = $urandom_range(1, 3);
        for (int r = 0; r < nr; r++) send_record(r == nr - 1);
        send_end();
    endtask

    task automatic send_broken_stream();
        repeat ($urandom_range(1, 12)) send_text(noisy_char());
        send_end();
    endtask

    task automatic test_directed_records();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(8'h78, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(8'h79, 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat(CH_LF, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(CH_CR, 1'b1, 1'b0);
        send_beat(CH_LF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_stream_edges();
        // end with nothing held, byte field ignored
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b0, 1'b0);
        send_beat(CH_CR, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b1);
        // span left open at the end
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b1);
        // escaping quote pair right before the end
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(CH_DQ, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_noise_bytes();
        repeat (100) begin
            if ($urandom_range(0, 19) == 0) send_end();
            else send_beat(noisy_char(), 1'($urandom_range(0, 1)), 1'b0);
        end
        send_end();
    endtask

    task automatic test_random_streams();
        while (beat_count < 560) begin
            if ($urandom_range(0, 7) == 0) send_broken_stream();
            else send_stream();
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (3) send_stream();
        send_broken_stream();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!idle_on) begin
                stall_left = 0;
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_result = '{o_byte_out, o_field_data, o_record_separator,
                            o_any_separator, o_last_result};
            if (lexed_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected beat: byte %h fd %b rs %b as %b lr %b",
                             seen_result.byte_out, seen_result.field_data,
                             seen_result.record_separator, seen_result.any_separator,
                             seen_result.last_result);
                mismatch_count++;
            end else begin
                due_result = lexed_q.pop_front();
                if (seen_result.byte_out !== due_result.byte_out
                    || seen_result.field_data !== due_result.field_data
                    || seen_result.record_separator !== due_result.record_separator
                    || seen_result.any_separator !== due_result.any_separator
                    || seen_result.last_result !== due_result.last_result) begin
                    if (mismatch_count < 10)
                        $display("mismatch: want %h %b%b%b%b got %h %b%b%b%b",
                                 due_result.byte_out, due_result.field_data,
                                 due_result.record_separator, due_result.any_separator,
                                 due_result.last_result, seen_result.byte_out,
                                 seen_result.field_data, seen_result.record_separator,
                                 seen_result.any_separator, seen_result.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int drain;
        idle_on        = 1'b1;
        beat_count     = 0;
        mismatch_count = 0;
        clear_lexer();
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_byte_value     <= 8'h00;
        i_codepoint_mark <= 1'b0;
        i_end_of_data    <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_stream_edges();
        test_noise_bytes();
        test_random_streams();
        test_steady_stream();
        i_valid <= 1'b0;

        drain = 0;
        while (lexed_q.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && lexed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/csvqm_pkg.sv
src/csvqm_classify.sv
src/csvqm_out_fifo.sv
src/csv_quote_aware_field_marker_top.sv
sim/testbench.sv
